@@ rtl/core/ctep_pkg.sv @@
// Shared constants and types for the circle edge point block.
// No dependencies; imported by ctep_cell and the top level.
package ctep_pkg;

    localparam int RADIUS_W        = 12;
    localparam int RADIUS_RESET    = 320;
    localparam int VEC_SCALE_SHIFT = 24;
    localparam int GAIN_SHIFT      = 30;
    // Inverse CORDIC gain 1/K in Q30.
    localparam logic [GAIN_SHIFT-1:0] INV_GAIN_Q30 = 30'd652032874;

    // Per-item control that travels along the cell chain.
    typedef struct packed {
        logic valid;
        logic flip;
        logic coincident;
    } t_ctl;

endpackage

@@ rtl/core/ctep_cell.sv @@
// One CORDIC cell: a vectoring step and the matching rotation step of one index.
// Depends on ctep_pkg for the control struct.
module ctep_cell import ctep_pkg::*; #(
    parameter int CW    = 16,
    parameter int VW    = 44,
    parameter int RW    = 45,
    parameter int STAGE = 0
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctl                 i_ctl,
    output logic                 o_ready,
    input  logic signed [VW-1:0] i_vx,
    input  logic signed [VW-1:0] i_vy,
    input  logic signed [RW-1:0] i_rx,
    input  logic signed [RW-1:0] i_ry,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    output t_ctl                 o_ctl,
    input  logic                 i_ready,
    output logic signed [VW-1:0] o_vx,
    output logic signed [VW-1:0] o_vy,
    output logic signed [RW-1:0] o_rx,
    output logic signed [RW-1:0] o_ry,
    output logic signed [CW-1:0] o_cx,
    output logic signed [CW-1:0] o_cy
);

    t_ctl                 r_ctl;
    logic signed [VW-1:0] r_vx, r_vy, n_vx, n_vy;
    logic signed [RW-1:0] r_rx, r_ry, n_rx, n_ry;
    logic signed [CW-1:0] r_cx, r_cy;
    logic                 dir;

    assign o_ready = !r_ctl.valid || i_ready;

    // The vectoring direction of this step steers the rotation step directly.
    always_comb begin
        dir = !i_vy[VW-1];
        if (dir) begin
            n_vx = i_vx + (i_vy >>> STAGE);
            n_vy = i_vy - (i_vx >>> STAGE);
            n_rx = i_rx - (i_ry >>> STAGE);
            n_ry = i_ry + (i_rx >>> STAGE);
        end else begin
            n_vx = i_vx - (i_vy >>> STAGE);
            n_vy = i_vy + (i_vx >>> STAGE);
            n_rx = i_rx + (i_ry >>> STAGE);
            n_ry = i_ry - (i_rx >>> STAGE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (o_ready) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_ctl.valid) begin
            r_vx <= n_vx;
            r_vy <= n_vy;
            r_rx <= n_rx;
            r_ry <= n_ry;
            r_cx <= i_cx;
            r_cy <= i_cy;
        end
    end

    assign o_ctl = r_ctl;
    assign o_vx  = r_vx;
    assign o_vy  = r_vy;
    assign o_rx  = r_rx;
    assign o_ry  = r_ry;
    assign o_cx  = r_cx;
    assign o_cy  = r_cy;

endmodule

@@ rtl/core/circle_edge_point_toward_target_core.sv @@
// An input passes through the entry stage, the CORDIC cells and the output stage to the result.
// Throughput: one item per cycle while the output is not stalled; every cell of the CORDIC chain holds one item.
// A stall at the output fills empty stages first, then backs up to the input.
// Reset clears all valid bits and sets the radius register to 320.
// Top level of the circle edge point block; depends on ctep_pkg and ctep_cell.
module circle_edge_point_toward_target_core import ctep_pkg::*; #(
    parameter int COORD_BITS    = 16,
    parameter int CORDIC_STAGES = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic signed [COORD_BITS-1:0] i_center_x,
    input  logic signed [COORD_BITS-1:0] i_center_y,
    input  logic signed [COORD_BITS-1:0] i_target_x,
    input  logic signed [COORD_BITS-1:0] i_target_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic signed [COORD_BITS-1:0] o_edge_x,
    output logic signed [COORD_BITS-1:0] o_edge_y,
    output logic                         o_coincident,
    output logic                         o_saturated,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [RADIUS_W-1:0]          i_cfg_data
);

    localparam int CW = COORD_BITS;
    localparam int DW = CW + 1;
    localparam int VW = DW + VEC_SCALE_SHIFT + 3;
    localparam int RW = RADIUS_W + GAIN_SHIFT + 3;
    localparam int SW = RW + CW + 1;
    localparam int N  = CORDIC_STAGES;
    localparam logic signed [RW-1:0] HALF = RW'(1) << (GAIN_SHIFT - 1);
    localparam logic signed [SW-1:0] MAXV = (SW'(1) << (CW - 1)) - SW'(1);
    localparam logic signed [SW-1:0] MINV = -MAXV - SW'(1);

    logic [RADIUS_W-1:0] r_radius;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= RADIUS_W'(RADIUS_RESET);
        end else if (i_cfg_valid) begin
            r_radius <= i_cfg_data;
        end
    end

    // Chain signals; index 0 is the entry stage output.
    t_ctl                 c_ctl [N+1];
    logic                 c_rdy [N+1];
    logic signed [VW-1:0] c_vx  [N+1];
    logic signed [VW-1:0] c_vy  [N+1];
    logic signed [RW-1:0] c_rx  [N+1];
    logic signed [RW-1:0] c_ry  [N+1];
    logic signed [CW-1:0] c_cx  [N+1];
    logic signed [CW-1:0] c_cy  [N+1];

    // Entry stage: difference, half-plane fold, scaling and radius product.
    t_ctl                          r_e_ctl;
    logic signed [VW-1:0]          r_e_vx, r_e_vy;
    logic signed [RW-1:0]          r_e_rx;
    logic signed [CW-1:0]          r_e_cx, r_e_cy;
    logic signed [DW-1:0]          dx, dy, adx, ady;
    logic                          flip;
    logic [RADIUS_W+GAIN_SHIFT-1:0] prod;
    logic                          e_ready;

    always_comb begin
        dx   = DW'(i_target_x) - DW'(i_center_x);
        dy   = DW'(i_target_y) - DW'(i_center_y);
        flip = dx[DW-1];
        adx  = flip ? -dx : dx;
        ady  = flip ? -dy : dy;
        prod = (RADIUS_W + GAIN_SHIFT)'(r_radius) * (RADIUS_W + GAIN_SHIFT)'(INV_GAIN_Q30);
    end

    assign e_ready    = !r_e_ctl.valid || c_rdy[0];
    assign o_in_stall = !e_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_ctl <= '0;
        end else if (e_ready) begin
            r_e_ctl.valid      <= i_in_valid;
            r_e_ctl.flip       <= flip;
            r_e_ctl.coincident <= (dx == '0) && (dy == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (e_ready && i_in_valid) begin
            r_e_vx <= VW'(adx) <<< VEC_SCALE_SHIFT;
            r_e_vy <= VW'(ady) <<< VEC_SCALE_SHIFT;
            r_e_rx <= signed'(RW'(prod));
            r_e_cx <= i_center_x;
            r_e_cy <= i_center_y;
        end
    end

    assign c_ctl[0] = r_e_ctl;
    assign c_vx[0]  = r_e_vx;
    assign c_vy[0]  = r_e_vy;
    assign c_rx[0]  = r_e_rx;
    assign c_ry[0]  = '0;
    assign c_cx[0]  = r_e_cx;
    assign c_cy[0]  = r_e_cy;

    for (genvar g = 0; g < N; g++) begin : g_cell
        ctep_cell #(.CW(CW), .VW(VW), .RW(RW), .STAGE(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (c_ctl[g]),
            .o_ready (c_rdy[g]),
            .i_vx    (c_vx[g]),
            .i_vy    (c_vy[g]),
            .i_rx    (c_rx[g]),
            .i_ry    (c_ry[g]),
            .i_cx    (c_cx[g]),
            .i_cy    (c_cy[g]),
            .o_ctl   (c_ctl[g+1]),
            .i_ready (c_rdy[g+1]),
            .o_vx    (c_vx[g+1]),
            .o_vy    (c_vy[g+1]),
            .o_rx    (c_rx[g+1]),
            .o_ry    (c_ry[g+1]),
            .o_cx    (c_cx[g+1]),
            .o_cy    (c_cy[g+1])
        );
    end

    // Output stage: unfold, round to an integer, add to the centre and saturate.
    logic                 r_o_valid;
    logic signed [CW-1:0] r_o_x, r_o_y;
    logic                 r_o_coin, r_o_sat;
    logic signed [RW-1:0] vx, vy, ox, oy;
    logic signed [SW-1:0] sx, sy;
    logic signed [CW-1:0] ex, ey;
    logic                 clip;
    logic                 o_ready_int;

    always_comb begin
        vx   = c_ctl[N].flip ? -c_rx[N] : c_rx[N];
        vy   = c_ctl[N].flip ? -c_ry[N] : c_ry[N];
        ox   = (vx + HALF) >>> GAIN_SHIFT;
        oy   = (vy + HALF) >>> GAIN_SHIFT;
        sx   = SW'(c_cx[N]) + SW'(ox);
        sy   = SW'(c_cy[N]) + SW'(oy);
        clip = 1'b0;
        if (sx > MAXV) begin
            ex = CW'(MAXV);
            clip = 1'b1;
        end else if (sx < MINV) begin
            ex = CW'(MINV);
            clip = 1'b1;
        end else begin
            ex = CW'(sx);
        end
        if (sy > MAXV) begin
            ey = CW'(MAXV);
            clip = 1'b1;
        end else if (sy < MINV) begin
            ey = CW'(MINV);
            clip = 1'b1;
        end else begin
            ey = CW'(sy);
        end
        // A target on the centre has no direction; the centre is returned as is.
        if (c_ctl[N].coincident) begin
            ex   = c_cx[N];
            ey   = c_cy[N];
            clip = 1'b0;
        end
    end

    assign o_ready_int = !r_o_valid || !i_out_stall;
    assign c_rdy[N]    = o_ready_int;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (o_ready_int) begin
            r_o_valid <= c_ctl[N].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready_int && c_ctl[N].valid) begin
            r_o_x    <= ex;
            r_o_y    <= ey;
            r_o_coin <= c_ctl[N].coincident;
            r_o_sat  <= clip;
        end
    end

    assign o_out_valid  = r_o_valid;
    assign o_edge_x     = r_o_x;
    assign o_edge_y     = r_o_y;
    assign o_coincident = r_o_coin;
    assign o_saturated  = r_o_sat;

endmodule

@@ dv/tb_circle_edge_point_toward_target_core.sv @@
// Testbench for circle_edge_point_toward_target_core: directed and random point pairs
// checked against a CORDIC predictor written here. Depends on ctep_pkg and the core RTL.
module tb_circle_edge_point_toward_target_core;
    import ctep_pkg::*;

    localparam int CB = 16;
    localparam int NS = 16;
    localparam int LAT = NS + 2;

    typedef struct {
        logic signed [CB-1:0] ex;
        logic signed [CB-1:0] ey;
        logic                 coin;
        logic                 sat;
    } t_edge;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic signed [CB-1:0] i_center_x = '0, i_center_y = '0, i_target_x = '0, i_target_y = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic signed [CB-1:0] o_edge_x, o_edge_y;
    logic                 o_coincident, o_saturated;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [RADIUS_W-1:0]  i_cfg_data = '0;

    logic [RADIUS_W-1:0]  radius_model = RADIUS_W'(RADIUS_RESET);
    t_edge                edge_queue[$];
    int                   err_count = 0;
    bit                   calm = 0;

    circle_edge_point_toward_target_core #(.COORD_BITS(CB), .CORDIC_STAGES(NS)) dut (.*);

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #50000000;
        $display("tb_circle_edge_point_toward_target_core: FAIL");
        $finish;
    end

    function automatic longint floor_shift(longint v, int s);
        return v >>> s;
    endfunction

    function automatic t_edge edge_point(longint cx, longint cy, longint tx, longint ty,
                                         longint rad);
        t_edge  r;
        longint dx, dy, x, y, nx, ny, ox, oy, sx, sy, hi, lo;
        bit     flip;
        bit [NS-1:0] dirs;
        dx = tx - cx;
        dy = ty - cy;
        hi = (1 <<< (CB - 1)) - 1;
        lo = -hi - 1;
        r.sat = 0;
        r.coin = (dx == 0 && dy == 0);
        if (r.coin) begin
            r.ex = CB'(cx);
            r.ey = CB'(cy);
            return r;
        end
        flip = dx < 0;
        if (flip) begin
            dx = -dx;
            dy = -dy;
        end
        x = dx <<< VEC_SCALE_SHIFT;
        y = dy <<< VEC_SCALE_SHIFT;
        for (int i = 0; i < NS; i++) begin
            dirs[i] = (y >= 0);
            if (dirs[i]) begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
            end else begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
            end
            x = nx;
            y = ny;
        end
        x = rad * longint'(INV_GAIN_Q30);
        y = 0;
        for (int i = 0; i < NS; i++) begin
            if (dirs[i]) begin
                nx = x - floor_shift(y, i);
                ny = y + floor_shift(x, i);
            end else begin
                nx = x + floor_shift(y, i);
                ny = y - floor_shift(x, i);
            end
            x = nx;
            y = ny;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        ox = floor_shift(x + (longint'(1) <<< (GAIN_SHIFT - 1)), GAIN_SHIFT);
        oy = floor_shift(y + (longint'(1) <<< (GAIN_SHIFT - 1)), GAIN_SHIFT);
        sx = cx + ox;
        sy = cy + oy;
        if (sx > hi) begin sx = hi; r.sat = 1; end
        if (sx < lo) begin sx = lo; r.sat = 1; end
        if (sy > hi) begin sy = hi; r.sat = 1; end
        if (sy < lo) begin sy = lo; r.sat = 1; end
        r.ex = CB'(sx);
        r.ey = CB'(sy);
        return r;
    endfunction

    function automatic bit idle_now();
        return !calm && ($urandom_range(99) < 14);
    endfunction

    // Output side: random stalls, and each result transfer is checked in order.
    always @(posedge i_clk) begin
        t_edge e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (edge_queue.size() == 0) begin
                $error("unexpected result");
                err_count++;
            end else begin
                e = edge_queue.pop_front();
                if (o_edge_x !== e.ex) begin
                    $error("edge_x exp %0d got %0d", e.ex, o_edge_x); err_count++;
                end
                if (o_edge_y !== e.ey) begin
                    $error("edge_y exp %0d got %0d", e.ey, o_edge_y); err_count++;
                end
                if (o_coincident !== e.coin) begin
                    $error("coincident exp %0b got %0b", e.coin, o_coincident); err_count++;
                end
                if (o_saturated !== e.sat) begin
                    $error("saturated exp %0b got %0b", e.sat, o_saturated); err_count++;
                end
            end
        end
        i_out_stall <= i_rst_n && idle_now();
    end

    // Valid stays high from one transfer to the next unless an idle cycle comes between.
    task automatic send_pair(logic signed [CB-1:0] cx, cy, tx, ty);
        if (idle_now()) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_now()) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_center_x <= cx;
        i_center_y <= cy;
        i_target_x <= tx;
        i_target_y <= ty;
        edge_queue.push_back(edge_point(cx, cy, tx, ty, radius_model));
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic write_radius(logic [RADIUS_W-1:0] rad);
        int n;
        n = 0;
        i_in_valid <= 1'b0;
        while (edge_queue.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LAT + 2) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= rad;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        radius_model = rad;
    endtask

    function automatic logic signed [CB-1:0] rnd_coord();
        case ($urandom_range(5))
            0: return CB'(16'sh7fff - $urandom_range(3));
            1: return CB'(16'sh8000 + $urandom_range(3));
            2: return CB'($urandom_range(400) - 200);
            default: return CB'($urandom());
        endcase
    endfunction

    task automatic test_directed();
        send_pair(0, 0, 0, 0);
        send_pair(100, -50, 100, -50);
        send_pair(0, 0, 1, 0);
        send_pair(0, 0, -1, 0);
        send_pair(0, 0, 0, 1);
        send_pair(0, 0, 0, -1);
        send_pair(0, 0, 300, 300);
        send_pair(0, 0, -300, 300);
        send_pair(0, 0, -300, -300);
        send_pair(16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000);
        send_pair(16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff);
        send_pair(16'sh7ff0, 0, 16'sh7fff, 0);
        send_pair(16'sh8010, 0, 16'sh8000, 5);
        send_pair(0, 16'sh7ff0, 3, 16'sh7fff);
        send_pair(-16'sd1, 16'sh7fff, 16'sh7fff, -16'sd1);
        send_pair(16'sh5555, 16'shaaaa, 16'shaaaa, 16'sh5555);
    endtask

    task automatic test_radius_extremes();
        write_radius(0);
        send_pair(0, 0, 500, 17);
        send_pair(16'sh7fff, 16'sh8000, 0, 0);
        send_pair(9, 9, 9, 9);
        write_radius(4095);
        send_pair(16'sh7000, 0, 16'sh7fff, 1);
        send_pair(16'sh8800, 16'sh8800, 16'sh8000, 16'sh8000);
        send_pair(0, 0, 1, -1);
    endtask

    task automatic test_random(int count);
        logic signed [CB-1:0] cx, cy;
        for (int k = 0; k < count; k++) begin
            calm = (k >= count / 3 && k < count / 2);
            cx = rnd_coord();
            cy = rnd_coord();
            if ($urandom_range(15) == 0) send_pair(cx, cy, cx, cy);
            else send_pair(cx, cy, rnd_coord(), rnd_coord());
        end
        calm = 0;
    endtask

    initial begin
        int n;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_radius_extremes();
        write_radius(RADIUS_W'($urandom_range(4095)));
        test_random(150);
        write_radius(1);
        test_random(100);
        write_radius(RADIUS_W'(RADIUS_RESET));
        test_random(200);
        n = 0;
        i_in_valid <= 1'b0;
        while (edge_queue.size() != 0 && n < 100000) begin
            @(posedge i_clk);
            n++;
        end
        repeat (LAT + 4) @(posedge i_clk);
        if (err_count == 0 && edge_queue.size() == 0) begin
            $display("tb_circle_edge_point_toward_target_core: PASS");
        end else begin
            $display("tb_circle_edge_point_toward_target_core: FAIL");
        end
        $finish;
    end

endmodule
